@@ hw/rtl/dhc_pkg.sv @@
// Shared types and constants for the datagram header checker.
// No dependencies; every other file in hw/rtl uses this package.
package dhc_pkg;

   localparam int HEADER_BYTES       = 12;
   localparam int MAX_DATAGRAM_BYTES = 2048;
   localparam int POS_W              = 12;

   localparam logic [POS_W-1:0] MAX_POS      = POS_W'(MAX_DATAGRAM_BYTES);
   localparam logic [POS_W-1:0] HDR_POS      = POS_W'(HEADER_BYTES);
   localparam logic [POS_W-1:0] OFS_VERSION  = POS_W'(4);
   localparam logic [POS_W-1:0] OFS_TYPE     = POS_W'(5);
   localparam logic [POS_W-1:0] OFS_LEN_LO   = POS_W'(6);
   localparam logic [POS_W-1:0] OFS_LEN_HI   = POS_W'(7);
   localparam logic [POS_W-1:0] OFS_SEQ      = POS_W'(8);
   localparam logic [POS_W-1:0] OFS_SEQ_END  = POS_W'(12);

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   localparam logic CSR_VERSION = 1'b0;
   localparam logic CSR_TYPE    = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        packet_valid;
      logic        sequence_error;
      logic [31:0] received_packets;
      logic [31:0] received_payload_bytes;
      logic [31:0] invalid_packets;
      logic [31:0] sequence_errors;
      logic [31:0] last_sequence;
   } rsp_type;

   // Summary of a datagram as of its final byte
   typedef struct packed {
      logic             header_ok;
      logic [POS_W-1:0] received;
      logic [15:0]      declared_length;
      logic [31:0]      seq_num;
   } dgram_end_type;

   // "ESPC" magic, offsets zero to three
   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = 8'h45;
         2'd1:    b = 8'h53;
         2'd2:    b = 8'h50;
         default: b = 8'h43;
      endcase
      return b;
   endfunction

endpackage

@@ hw/rtl/dhc_parser.sv @@
// Header field capture and per-datagram byte position.
// Depends on dhc_pkg.
module dhc_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  dhc_pkg::req_type      item,
   input  logic [7:0]            expected_version,
   input  logic [7:0]            expected_type,
   output dhc_pkg::dgram_end_type dgram_end
);

   logic [dhc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      match_ff, match_in;
   logic [15:0]               len_ff, len_in;
   logic [31:0]               seq_ff, seq_in;
   logic [7:0]                b;

   assign b = item.data_byte;

   always_comb begin
      pos_in   = pos_ff;
      match_in = match_ff;
      len_in   = len_ff;
      seq_in   = seq_ff;
      if (pos_ff < dhc_pkg::MAX_POS) begin
         pos_in = pos_ff + dhc_pkg::POS_W'(1);
         if (pos_ff < dhc_pkg::OFS_VERSION) begin
            if (b != dhc_pkg::magic_byte(pos_ff[1:0])) match_in = 1'b0;
         end else if (pos_ff == dhc_pkg::OFS_VERSION) begin
            if (b != expected_version) match_in = 1'b0;
         end else if (pos_ff == dhc_pkg::OFS_TYPE) begin
            if (b != expected_type) match_in = 1'b0;
         end else if (pos_ff == dhc_pkg::OFS_LEN_LO) begin
            len_in[7:0] = b;
         end else if (pos_ff == dhc_pkg::OFS_LEN_HI) begin
            len_in[15:8] = b;
         end else if (pos_ff >= dhc_pkg::OFS_SEQ && pos_ff < dhc_pkg::OFS_SEQ_END) begin
            seq_in[8*pos_ff[1:0] +: 8] = b;
         end
      end
   end

   assign dgram_end.header_ok       = match_in;
   assign dgram_end.received        = pos_in;
   assign dgram_end.declared_length = len_in;
   assign dgram_end.seq_num         = seq_in;

   always_ff @(posedge clock) begin
      if (reset || (step && (item.cmd == dhc_pkg::CMD_CLEAR || item.last_byte))) begin
         pos_ff   <= '0;
         match_ff <= 1'b1;
         len_ff   <= '0;
         seq_ff   <= '0;
      end else if (step) begin
         pos_ff   <= pos_in;
         match_ff <= match_in;
         len_ff   <= len_in;
         seq_ff   <= seq_in;
      end
   end

endmodule

@@ hw/rtl/dhc_stats.sv @@
// Datagram validity decision, running counters and sequence tracking.
// Depends on dhc_pkg.
module dhc_stats (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  finish,
   input  logic                  clear,
   input  dhc_pkg::dgram_end_type dgram_end,
   output dhc_pkg::rsp_type      result
);

   logic [31:0] pkt_ff, pkt_in;
   logic [31:0] pay_ff, pay_in;
   logic [31:0] inv_ff, inv_in;
   logic [31:0] serr_ff, serr_in;
   logic [31:0] recent_ff, recent_in;
   logic [31:0] next_seq_ff, next_seq_in;
   logic        seen_ff, seen_in;
   logic [dhc_pkg::POS_W-1:0] payload_len;
   logic        valid;
   logic        seq_err;

   assign payload_len = dgram_end.received - dhc_pkg::HDR_POS;
   assign valid = (dgram_end.received >= dhc_pkg::HDR_POS) && dgram_end.header_ok &&
                  (16'(payload_len) == dgram_end.declared_length);
   assign seq_err = valid && seen_ff && (dgram_end.seq_num != next_seq_ff);

   always_comb begin
      pkt_in      = pkt_ff;
      pay_in      = pay_ff;
      inv_in      = inv_ff;
      serr_in     = serr_ff;
      recent_in   = recent_ff;
      next_seq_in = next_seq_ff;
      seen_in     = seen_ff;
      if (valid) begin
         pkt_in      = pkt_ff + 32'd1;
         pay_in      = pay_ff + 32'(payload_len);
         seen_in     = 1'b1;
         next_seq_in = dgram_end.seq_num + 32'd1;
         recent_in   = dgram_end.seq_num;
         if (seq_err) serr_in = serr_ff + 32'd1;
      end else begin
         inv_in = inv_ff + 32'd1;
      end
   end

   assign result.packet_valid           = valid;
   assign result.sequence_error         = seq_err;
   assign result.received_packets       = pkt_in;
   assign result.received_payload_bytes = pay_in;
   assign result.invalid_packets        = inv_in;
   assign result.sequence_errors        = serr_in;
   assign result.last_sequence          = recent_in;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         pkt_ff      <= '0;
         pay_ff      <= '0;
         inv_ff      <= '0;
         serr_ff     <= '0;
         recent_ff   <= '0;
         next_seq_ff <= '0;
         seen_ff     <= 1'b0;
      end else if (finish) begin
         pkt_ff      <= pkt_in;
         pay_ff      <= pay_in;
         inv_ff      <= inv_in;
         serr_ff     <= serr_in;
         recent_ff   <= recent_in;
         next_seq_ff <= next_seq_in;
         seen_ff     <= seen_in;
      end
   end

endmodule

@@ hw/rtl/datagram_header_checker_core.sv @@
// Top level of the datagram header checker: input register, parser, stats, result register.
// Depends on dhc_pkg, dhc_parser and dhc_stats.
//
// Usage:
//   req_*  : one datagram byte (or a clear command) per transfer, last_byte on the final byte.
//   rsp_*  : one result per datagram, issued for its final byte; counters are post-update.
//   csr_*  : register writes, index 0 expected version, index 1 expected type; always ready.
// Path: a final byte's result passes the input register and then the result register before rsp_valid.
// Throughput: one byte per cycle while req_stall is low, set by the single input register
//   feeding one combinational parse/count pass into the result register.
// Reset (synchronous): clears the datagram in progress, all counters and sequence tracking,
//   and sets both expected bytes to 1. No result is pending after reset.
// Clear command: counters and datagram in progress cleared, no result.
// When rsp_stall holds a result, the next final byte waits in the input register and
//   req_stall rises; bytes that produce no result are not held up by a full output.
module datagram_header_checker_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dhc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dhc_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [7:0]       csr_wdata
);

   logic                   in_valid_ff;
   dhc_pkg::req_type       in_data_ff;
   logic [7:0]             version_ff;
   logic [7:0]             type_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   dhc_pkg::rsp_type       rsp_data_ff;
   dhc_pkg::dgram_end_type dgram_end;
   dhc_pkg::rsp_type       result;
   logic                   is_final;
   logic                   advance;
   logic                   out_free;

   assign csr_ready = 1'b1;

   assign is_final = (in_data_ff.cmd == dhc_pkg::CMD_BYTE) && in_data_ff.last_byte;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = in_valid_ff && (!is_final || out_free);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_ff <= 8'd1;
         type_ff    <= 8'd1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == dhc_pkg::CSR_VERSION) version_ff <= csr_wdata;
         if (csr_index == dhc_pkg::CSR_TYPE)    type_ff    <= csr_wdata;
      end
   end

   dhc_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (advance),
      .item             (in_data_ff),
      .expected_version (version_ff),
      .expected_type    (type_ff),
      .dgram_end        (dgram_end)
   );

   dhc_stats u_stats (
      .clock     (clock),
      .reset     (reset),
      .finish    (advance && is_final),
      .clear     (advance && in_data_ff.cmd == dhc_pkg::CMD_CLEAR),
      .dgram_end (dgram_end),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (advance && is_final) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_final) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
